// File: src/ascii_distance_frame_parser_macros.svh
// assertion macros shared by the checker of the frame parser
// no dependencies; include by bare file name
`ifndef ASCII_DISTANCE_FRAME_PARSER_MACROS_SVH
`define ASCII_DISTANCE_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADFP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adfp check failed");

// next-cycle implication, disabled during reset
`define ADFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adfp check failed");

// next-cycle implication that stays armed through reset
`define ADFP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("adfp check failed");

`endif

// File: src/adfp_pkg.sv
// types and constants of the ascii distance frame parser
// no dependencies; used by adfp_step and the top level
`timescale 1ns / 1ps
`default_nettype none

package adfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AccW   = 17;
  localparam int unsigned CountW = 3;
  localparam int unsigned DistW  = 16;

  localparam logic [ByteW-1:0] CH_G  = 8'h47;
  localparam logic [ByteW-1:0] CH_A  = 8'h61;
  localparam logic [ByteW-1:0] CH_P  = 8'h70;
  localparam logic [ByteW-1:0] CH_EQ = 8'h3D;
  localparam logic [ByteW-1:0] CH_0  = 8'h30;
  localparam logic [ByteW-1:0] CH_9  = 8'h39;
  localparam logic [ByteW-1:0] CH_M  = 8'h6D;
  localparam logic [ByteW-1:0] CH_CR = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF = 8'h0A;

  localparam logic [CountW-1:0] FEWEST_DIGITS = 3'd4;
  localparam logic [CountW-1:0] MOST_DIGITS   = 3'd5;
  localparam logic [AccW-1:0]   DIST_MAX      = 17'd65535;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_A      = 4'd1,
    PH_P      = 4'd2,
    PH_EQ     = 4'd3,
    PH_DIGITS = 4'd4,
    PH_M2     = 4'd5,
    PH_CR     = 4'd6,
    PH_LF     = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   acc;
    logic [CountW-1:0] digit_count;
  } adfp_state_t;

  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] distance;
    logic             status;
  } adfp_result_t;

  localparam adfp_state_t STATE_RESET = '{phase: PH_HUNT, acc: '0, digit_count: '0};

endpackage

`default_nettype wire

// File: src/adfp_step.sv
// per-byte parse step: next frame state and optional result
// depends on adfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module adfp_step
  import adfp_pkg::*;
(
  input  adfp_state_t      cur,
  input  logic [ByteW-1:0] rx_byte,
  output adfp_state_t      nxt,
  output adfp_result_t     res
);

  logic            byte_numeral;
  logic [AccW-1:0] acc_x10;
  logic [AccW-1:0] acc_dig;
  logic [AccW-1:0] acc_sat;

  assign byte_numeral = rx_byte inside {[CH_0:CH_9]};
  // acc*10 as 8*acc + 2*acc, wrapping at the accumulator width
  assign acc_x10  = {cur.acc[AccW-4:0], 3'b000} + {cur.acc[AccW-2:0], 1'b0};
  assign acc_dig  = acc_x10 + {{(AccW-4){1'b0}}, rx_byte[3:0]};
  assign acc_sat  = (cur.acc > DIST_MAX) ? DIST_MAX : cur.acc;

  always_comb begin
    nxt = cur;
    res = '{valid: 1'b0, distance: '0, status: STATUS_OK};
    case (cur.phase)
      PH_HUNT: begin
        if (rx_byte == CH_G) begin
          nxt = '{phase: PH_A, acc: '0, digit_count: '0};
        end
      end
      PH_A: begin
        if (rx_byte == CH_A) nxt.phase = PH_P;
        else res.valid = 1'b1;
      end
      PH_P: begin
        if (rx_byte == CH_P) nxt.phase = PH_EQ;
        else res.valid = 1'b1;
      end
      PH_EQ: begin
        if (rx_byte == CH_EQ) nxt.phase = PH_DIGITS;
        else res.valid = 1'b1;
      end
      PH_DIGITS: begin
        if (byte_numeral) begin
          if (cur.digit_count >= MOST_DIGITS) begin
            res.valid = 1'b1;
          end else begin
            nxt.acc         = acc_dig;
            nxt.digit_count = cur.digit_count + 3'd1;
          end
        end else if (cur.digit_count < FEWEST_DIGITS || rx_byte != CH_M) begin
          res.valid = 1'b1;
        end else begin
          nxt.phase = PH_M2;
        end
      end
      PH_M2: begin
        if (rx_byte == CH_M) nxt.phase = PH_CR;
        else res.valid = 1'b1;
      end
      PH_CR: begin
        if (rx_byte == CH_CR) nxt.phase = PH_LF;
        else res.valid = 1'b1;
      end
      PH_LF: begin
        res.valid = 1'b1;
        if (rx_byte == CH_LF) begin
          res.distance = acc_sat[DistW-1:0];
          res.status   = STATUS_OK;
          nxt          = STATE_RESET;
        end
      end
      default: begin
        nxt = STATE_RESET;
      end
    endcase
    // any emitted error clears the frame and returns to hunting
    if (res.valid && !(cur.phase == PH_LF && rx_byte == CH_LF)) begin
      res.distance = '0;
      res.status   = STATUS_ERR;
      nxt          = STATE_RESET;
    end
  end

endmodule

`default_nettype wire

// File: src/ascii_distance_frame_parser.sv
// top level of the ascii distance frame parser ("Gap=" digits "mm" CR LF)
// depends on adfp_pkg and adfp_step
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   in       | in_valid / in_ready  | rx_byte[7:0]
//   out      | out_valid / out_ready| distance[15:0], status
//
// one byte per cycle sustained while out_ready is high: byte register -> parse step -> result register
// a byte waits in the byte register until the result register is free or being drained
// rst (synchronous) clears both valid flags and returns the parser to hunting
// a full result register that is not taken holds the byte stage; the byte
// stage still takes a transfer while it is empty
`timescale 1ns / 1ps
`default_nettype none

module ascii_distance_frame_parser
  import adfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DistW-1:0] distance,
  output logic             status
);

  // byte stage
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;

  // frame state
  adfp_state_t  st;
  adfp_state_t  st_next;
  adfp_result_t res;

  logic advance;

  // the byte stage moves on whenever the result register is free or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  adfp_step u_step (
    .cur     (st),
    .rx_byte (s1_byte),
    .nxt     (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      // input transfer into the byte stage
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        st <= st_next;
      end

      // result register: drain on transfer, load when a byte yields a result
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance && res.valid) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
    if (advance && res.valid) begin
      distance <= res.distance;
      status   <= res.status;
    end
  end

endmodule

`default_nettype wire

// File: src/adfp_checker.sv
// port-level checks for the ascii distance frame parser, bound to the top level
// depends on ascii_distance_frame_parser_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_distance_frame_parser_macros.svh"

module adfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] distance,
  input logic        status
);

  // a stalled result holds
  `ADFP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(distance) && $stable(status))
  // a waiting input byte holds
  `ADFP_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(rx_byte))
  // error results carry zero distance
  `ADFP_ASSERT_NOW(a_err_zero, clk, rst, out_valid && status, distance == 16'd0)
  // with the result register empty the input side is never stalled
  `ADFP_ASSERT_NOW(a_no_stall, clk, rst, !out_valid, in_ready)
  // nothing comes out right after reset
  `ADFP_ASSERT_ALWAYS_NEXT(a_rst_quiet, clk, rst, !out_valid)

endmodule

bind ascii_distance_frame_parser adfp_checker u_adfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .rx_byte   (rx_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .distance  (distance),
  .status    (status)
);

`default_nettype wire

// File: tb/sv/tb_ascii_distance_frame_parser.sv
// testbench for the ascii distance frame parser: byte stream in, distance readings out
// depends on adfp_pkg and the ascii_distance_frame_parser top level
// a parse model of its own predicts every reading; the monitor checks them in order
`timescale 1ns / 1ps

module tb_ascii_distance_frame_parser;
  import adfp_pkg::*;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             status;
  } reading_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned PhaseBytes = 500;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DistW-1:0] distance;
  logic             status;

  // bytes waiting to be driven, readings waiting to come out
  logic [ByteW-1:0] pending_bytes[$];
  reading_t         expected_readings[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          in_took = 1'b0;

  // parse state of the model
  phase_t            frame_phase = PH_HUNT;
  logic [AccW-1:0]   frame_value = '0;
  logic [CountW-1:0] digits_seen = '0;

  ascii_distance_frame_parser uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .distance (distance),
    .status   (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // back to hunting for the next 'G'
  task automatic back_to_hunt();
    frame_phase = PH_HUNT;
    frame_value = '0;
    digits_seen = '0;
  endtask

  // the byte that breaks a frame is used up by the error reading
  task automatic frame_broken();
    expected_readings.push_back('{distance: '0, status: STATUS_ERR});
    back_to_hunt();
  endtask

  // advance the model by one accepted byte
  task automatic parse_byte(input logic [ByteW-1:0] b);
    logic [DistW-1:0] reading_mm;
    case (frame_phase)
      PH_HUNT: begin
        if (b == CH_G) begin
          frame_phase = PH_A;
          frame_value = '0;
          digits_seen = '0;
        end
      end
      PH_A: begin
        if (b == CH_A) frame_phase = PH_P;
        else frame_broken();
      end
      PH_P: begin
        if (b == CH_P) frame_phase = PH_EQ;
        else frame_broken();
      end
      PH_EQ: begin
        if (b == CH_EQ) frame_phase = PH_DIGITS;
        else frame_broken();
      end
      PH_DIGITS: begin
        if (b >= CH_0 && b <= CH_9) begin
          // a sixth digit lands where the suffix belongs
          if (digits_seen >= MOST_DIGITS) begin
            frame_broken();
          end else begin
            frame_value = frame_value * 17'd10 + AccW'(b - CH_0);
            digits_seen = digits_seen + 3'd1;
          end
        end else if (digits_seen < FEWEST_DIGITS || b != CH_M) begin
          frame_broken();
        end else begin
          frame_phase = PH_M2;
        end
      end
      PH_M2: begin
        if (b == CH_M) frame_phase = PH_CR;
        else frame_broken();
      end
      PH_CR: begin
        if (b == CH_CR) frame_phase = PH_LF;
        else frame_broken();
      end
      PH_LF: begin
        if (b == CH_LF) begin
          // five digits reach 99999, the port holds 16 bits
          reading_mm = (frame_value > DIST_MAX) ? DIST_MAX[DistW-1:0] : frame_value[DistW-1:0];
          expected_readings.push_back('{distance: reading_mm, status: STATUS_OK});
          back_to_hunt();
        end else begin
          frame_broken();
        end
      end
      default: back_to_hunt();
    endcase
  endtask

  // driver: new byte or idle at the falling edge, valid held until the transfer
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_took) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check readings, then feed accepted bytes to the model
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      // a byte passes the byte register before the result register, so checking first is safe
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          error_count++;
          $display("%0t: unexpected reading: expected none, got distance %0d status %0d",
                   $time, distance, status);
        end else begin
          want = expected_readings.pop_front();
          if (distance !== want.distance) begin
            error_count++;
            $display("%0t: distance mismatch: expected %0d, got %0d",
                     $time, want.distance, distance);
          end
          if (status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, status);
          end
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) parse_byte(rx_byte);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  // one frame with the given digit count; optionally one byte replaced at random
  task automatic push_frame(input int ndigits, input int unsigned value, input bit corrupt,
                            ref int unsigned counted);
    logic [ByteW-1:0] frame[$];
    int unsigned      scale;
    int unsigned      pos;
    frame = '{CH_G, CH_A, CH_P, CH_EQ};
    scale = 1;
    for (int k = 1; k < ndigits; k++) scale = scale * 10;
    for (int k = 0; k < ndigits; k++) begin
      frame.push_back(CH_0 + ByteW'((value / scale) % 10));
      scale = (scale > 1) ? scale / 10 : 1;
    end
    frame.push_back(CH_M);
    frame.push_back(CH_M);
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
    if (corrupt) begin
      pos = $urandom_range(frame.size() - 1);
      frame[pos] = ByteW'($urandom_range(255));
    end
    counted += frame.size();
    foreach (frame[i]) pending_bytes.push_back(frame[i]);
  endtask

  // mostly good frames, some broken ones, some line noise
  task automatic push_random_traffic(input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    int unsigned value;
    int          nd;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(99);
      nd = ($urandom_range(1) == 0) ? 4 : 5;
      if ($urandom_range(9) == 0) value = 65530 + $urandom_range(10);
      else value = $urandom_range((nd == 4) ? 9999 : 99999);
      if (pick < 68) begin
        push_frame(nd, value, 1'b0, counted);
      end else if (pick < 82) begin
        push_frame(nd, value, 1'b1, counted);
      end else if (pick < 90) begin
        // digit count out of range: too few, or six or seven
        nd = ($urandom_range(1) == 0) ? $urandom_range(3) : 6 + $urandom_range(1);
        push_frame(nd, $urandom_range(999999), 1'b0, counted);
      end else begin
        repeat ($urandom_range(1, 6)) pending_bytes.push_back(ByteW'($urandom_range(255)));
      end
    end
  endtask

  // sender holds off until every reading has come out
  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_readings.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // directed: ignored bytes while hunting, value extremes, several ways a frame breaks
    // CR and LF written as octal escapes
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    push_text("Gap=0000mm\015\012");
    push_text("Gap=99999mm\015\012");
    push_text("Gap=65536mm\015\012");
    push_text("Gap=123mm\015\012");
    push_text("Gap=123456");
    push_text("GaGap=1234mm\015\012");
    push_text("Gap=12345m\015");
    push_text("Gap=1234mm\015X");
    push_text("Gb");
    drain();

    // no idling on either side
    push_random_traffic(PhaseBytes);
    drain();

    sender_idle_pct = 51;
    push_random_traffic(PhaseBytes);
    drain();

    sender_idle_pct = 0;
    recv_stall_pct = 51;
    push_random_traffic(PhaseBytes);
    drain();

    sender_idle_pct = 10;
    recv_stall_pct = 10;
    push_random_traffic(PhaseBytes);
    drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
